FILE: hdl/cfa_pkg.sv
// Shared types, field widths and codes of the contiguous frame allocator.
package cfa_pkg;

   localparam int FRAME_W        = 20;
   localparam int CNT_W          = 11;
   localparam int MODE_W         = 2;
   localparam int STATUS_W       = 2;
   localparam int FSTATE_W       = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 20;
   localparam int DEF_MAX_FRAMES = 1024;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MARK    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTHEAD = 2'd3;

   // Per-frame states kept in the map memory.
   localparam logic [FSTATE_W-1:0] FS_FREE = 2'd0;
   localparam logic [FSTATE_W-1:0] FS_USED = 2'd1;
   localparam logic [FSTATE_W-1:0] FS_HEAD = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FRAME    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_FRAMES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE_FIRST = 2'd2;

   localparam logic [FRAME_W-1:0] RST_BASE_FRAME  = 20'd0;
   localparam logic [CNT_W-1:0]   RST_POOL_FRAMES = 11'd1024;
   localparam logic               RST_RESERVE     = 1'b0;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FRAME_W-1:0] first_frame;
      logic [CNT_W-1:0]   count;
   } cfa_req_type;

   typedef struct packed {
      logic [FRAME_W-1:0]  result_frame;
      logic [STATUS_W-1:0] status;
   } cfa_rsp_type;

   typedef struct packed {
      logic [FRAME_W-1:0] base_frame;
      logic [CNT_W-1:0]   pool_frames;
      logic               reserve_first;
   } cfa_cfg_type;

   typedef struct packed {
      logic req_ready;
      logic done;
   } cfa_stat_type;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_MARK,
      S_REL_HEAD,
      S_REL_NEXT,
      S_RESP
   } cfa_state_type;

endpackage

FILE: hdl/cfa_engine.sv
// Frame map memory and the sequencer that scans, marks, releases and clears it.
module cfa_engine #(
   parameter int MAX_FRAMES = cfa_pkg::DEF_MAX_FRAMES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfa_pkg::cfa_cfg_type cfg,
   input  logic                 req_valid,
   input  cfa_pkg::cfa_req_type req,
   input  logic                 slot_free,
   output cfa_pkg::cfa_stat_type stat,
   output cfa_pkg::cfa_rsp_type result
);
   import cfa_pkg::*;

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int NW = $clog2(MAX_FRAMES + 1);
   localparam logic [NW-1:0] ONE_N = NW'(1);
   localparam logic [NW-1:0] LAST_N = NW'(MAX_FRAMES - 1);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   logic [FSTATE_W-1:0] map_mem [MAX_FRAMES];
   logic [FSTATE_W-1:0] rd_data_ff;
   logic                mem_we;
   logic [FSTATE_W-1:0] mem_wdata;

   cfa_state_type       state_ff, state_in;
   logic [NW-1:0]       ptr_ff, ptr_in;
   logic                reply_ff, reply_in;
   logic [NW-1:0]       start_ff, start_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic                first_ff, first_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [FRAME_W-1:0]  rel_ff, rel_in;
   logic                below_ff, below_in;
   logic [FRAME_W-1:0]  res_frame_ff, res_frame_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic [NW-1:0]       pool_n;
   logic [FRAME_W:0]    diff;
   logic [FRAME_W:0]    rel_end;
   logic                rel_outside;
   logic [NW-1:0]       ptr_nx;
   logic [NW-1:0]       run_start;
   logic [CNT_W-1:0]    run_nx;

   // The pool size is clipped to the depth of the map memory.
   assign pool_n = (32'(cfg.pool_frames) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES)
                                                             : NW'(cfg.pool_frames);
   assign diff        = {1'b0, req.first_frame} - {1'b0, cfg.base_frame};
   assign rel_outside = below_ff || (rel_ff >= {{(FRAME_W - NW){1'b0}}, pool_n});
   assign rel_end     = {1'b0, rel_ff} + {{(FRAME_W + 1 - CNT_W){1'b0}}, cnt_ff};
   assign ptr_nx      = ptr_ff + ONE_N;
   assign run_start   = (run_ff == '0) ? ptr_ff : start_ff;
   assign run_nx      = run_ff + ONE_C;

   // Reads always fetch the entry the next cycle will look at. A read only lands on the
   // entry being written in the last cycle of a mark or release, and that data is unused.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[ptr_ff[AW-1:0]] <= mem_wdata;
      end
      rd_data_ff <= map_mem[ptr_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         ptr_ff   <= '0;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         reply_ff <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      run_ff        <= run_in;
      remain_ff     <= remain_in;
      first_ff      <= first_in;
      mode_ff       <= mode_in;
      cnt_ff        <= cnt_in;
      rel_ff        <= rel_in;
      below_ff      <= below_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      reply_in      = reply_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      remain_in     = remain_ff;
      first_in      = first_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      rel_in        = rel_ff;
      below_in      = below_ff;
      res_frame_in  = res_frame_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_wdata     = FS_FREE;
      stat.req_ready = 1'b0;
      stat.done      = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            // A clear leaves frame 0 reserved when asked; the pass after reset never does.
            mem_we = 1'b1;
            mem_wdata = (reply_ff && cfg.reserve_first && ptr_ff == '0) ? FS_USED : FS_FREE;
            if (ptr_ff == LAST_N) begin
               ptr_in        = '0;
               res_frame_in  = '0;
               res_status_in = STAT_OK;
               state_in      = reply_ff ? S_RESP : S_IDLE;
            end else begin
               ptr_in = ptr_nx;
            end
         end
         S_IDLE: begin
            stat.req_ready = 1'b1;
            if (req_valid) begin
               mode_in      = req.mode;
               cnt_in       = req.count;
               rel_in       = diff[FRAME_W-1:0];
               below_in     = diff[FRAME_W];
               res_frame_in = '0;
               unique case (req.mode)
                  MODE_ALLOC: begin
                     if (req.count == '0 || pool_n == '0) begin
                        res_status_in = STAT_NOSPACE;
                        state_in      = S_RESP;
                     end else begin
                        ptr_in   = '0;
                        run_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  MODE_MARK, MODE_RELEASE: begin
                     state_in = S_CHECK;
                  end
                  MODE_CLEAR: begin
                     ptr_in   = '0;
                     reply_in = 1'b1;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     state_in = S_CHECK;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (mode_ff == MODE_MARK) begin
               if (rel_outside || rel_end > {{(FRAME_W + 1 - NW){1'b0}}, pool_n}) begin
                  res_status_in = STAT_RANGE;
                  state_in      = S_RESP;
               end else begin
                  ptr_in    = rel_ff[NW-1:0];
                  remain_in = (cnt_ff == '0) ? '0 : cnt_ff - ONE_C;
                  first_in  = 1'b1;
                  state_in  = S_MARK;
               end
            end else begin
               if (rel_outside) begin
                  res_status_in = STAT_RANGE;
                  state_in      = S_RESP;
               end else begin
                  ptr_in   = rel_ff[NW-1:0];
                  state_in = S_REL_HEAD;
               end
            end
         end
         S_SCAN: begin
            // rd_data_ff holds the state of frame ptr_ff.
            if (rd_data_ff == FS_FREE && run_nx == cnt_ff) begin
               ptr_in    = run_start;
               start_in  = run_start;
               remain_in = cnt_ff - ONE_C;
               first_in  = 1'b1;
               state_in  = S_MARK;
            end else begin
               if (rd_data_ff == FS_FREE) begin
                  start_in = run_start;
                  run_in   = run_nx;
               end else begin
                  run_in = '0;
               end
               if (ptr_nx == pool_n) begin
                  res_status_in = STAT_NOSPACE;
                  state_in      = S_RESP;
               end else begin
                  ptr_in = ptr_nx;
               end
            end
         end
         S_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = first_ff ? FS_HEAD : FS_USED;
            first_in  = 1'b0;
            if (remain_ff == '0) begin
               res_status_in = STAT_OK;
               res_frame_in  = (mode_ff == MODE_ALLOC)
                             ? cfg.base_frame + {{(FRAME_W - NW){1'b0}}, start_ff}
                             : '0;
               state_in      = S_RESP;
            end else begin
               remain_in = remain_ff - ONE_C;
               ptr_in    = ptr_nx;
            end
         end
         S_REL_HEAD, S_REL_NEXT: begin
            if ((state_ff == S_REL_HEAD && rd_data_ff == FS_HEAD) ||
                (state_ff == S_REL_NEXT && rd_data_ff == FS_USED)) begin
               mem_we    = 1'b1;
               mem_wdata = FS_FREE;
               if (ptr_nx == pool_n) begin
                  res_status_in = STAT_OK;
                  state_in      = S_RESP;
               end else begin
                  ptr_in   = ptr_nx;
                  state_in = S_REL_NEXT;
               end
            end else begin
               res_status_in = (state_ff == S_REL_HEAD) ? STAT_NOTHEAD : STAT_OK;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            stat.done = 1'b1;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.result_frame = res_frame_ff;
   assign result.status       = res_status_ff;

endmodule

FILE: hdl/contiguous_frame_allocator_core.sv
// Top level of the first-fit contiguous frame allocator: registers, response stage, engine.
//
// The allocator keeps a two-bit state for each frame of the pool in one memory with a
// registered read port, so a request that walks the map does so one frame per clock.
// An allocate scans the pool (its size clipped to MAX_FRAMES) from the start for the
// first free run of count frames and then writes the run; an allocate of zero frames
// or from an empty pool is answered without a scan. A mark checks the bounds and then
// writes count frames, or one frame when count is zero. A release checks the bounds,
// reads the head and frees it and each used frame after it until the run or the pool
// ends, and answers without writing when it finds no head. A request that fails the
// bounds check is answered after the check, and a clear sweeps the whole map. While the
// output register still holds an unaccepted response, the engine waits in its last cycle.
// After reset the block runs a clearing pass over every entry of the map and holds
// req_ready low until it is done; configuration writes are taken at any time. One
// transaction is worked at a time, and the next one is accepted while the previous
// response still waits in the output register.
module contiguous_frame_allocator_core #(
   parameter int MAX_FRAMES = cfa_pkg::DEF_MAX_FRAMES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cfa_pkg::cfa_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cfa_pkg::cfa_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [cfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cfa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cfa_pkg::*;

   cfa_cfg_type  cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   cfa_rsp_type  rsp_data_ff, rsp_data_in;
   cfa_stat_type eng_stat;
   cfa_rsp_type  eng_result;
   logic         slot_free;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_FRAME:    cfg_in.base_frame    = csr_wdata[FRAME_W-1:0];
            CSR_POOL_FRAMES:   cfg_in.pool_frames   = csr_wdata[CNT_W-1:0];
            CSR_RESERVE_FIRST: cfg_in.reserve_first = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_frame    <= RST_BASE_FRAME;
         cfg_ff.pool_frames   <= RST_POOL_FRAMES;
         cfg_ff.reserve_first <= RST_RESERVE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfa_engine #(
      .MAX_FRAMES(MAX_FRAMES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req       (req_data),
      .slot_free (slot_free),
      .stat      (eng_stat),
      .result    (eng_result)
   );

   // The output register frees the engine as soon as a response is parked in it.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (eng_stat.done && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = eng_stat.req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The engine never offers a result while it is free to take a new transaction.
   a_done_not_idle: assert property (@(posedge clock) disable iff (reset)
      !(eng_stat.done && eng_stat.req_ready))
      else $error("engine reports a result while accepting requests");

   // A result handed over to a free output slot shows up as a valid response.
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (eng_stat.done && slot_free) |=> (rsp_valid && !eng_stat.done))
      else $error("result handed to output slot did not appear");

   // The map is being cleared right after reset, so no request is taken.
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted before the clearing pass finished");
`endif

endmodule
